>>> hdl/ahts_pkg.sv
// Package for the aging hash table store: sizes, codes and the slot hash.
// No dependencies.
`default_nettype none
package ahts_pkg;
  localparam int ENTRIES = 256;
  localparam int SLOTS = 512;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int SV_W = IDX_W + 1;
  localparam logic [31:0] HASH_MUL = 32'd2654435761;

  localparam logic [1:0] MODE_FIND = 2'd0;
  localparam logic [1:0] MODE_CREATE = 2'd1;
  localparam logic [1:0] MODE_PRUNE = 2'd2;

  localparam logic [2:0] ST_FOUND = 3'd0;
  localparam logic [2:0] ST_CREATED = 3'd1;
  localparam logic [2:0] ST_ABSENT = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_PRUNED = 3'd4;
endpackage
`default_nettype wire

>>> hdl/aging_hash_table_store.sv
// Top level of the aging hash table store: entry arrays, slot table, sequencer.
// Depends on ahts_pkg.
//
// channel  direction  handshake          words
// in       input      in_valid_i/ready_o mode, key_id, frame_stamp, min_frame
// out      output     out_valid_o/ready_i status, entry_index, removed_count
//
// Find/create: a hash multiply, then for each probed slot a slot read, a key read and
// a compare.
// Prune: compaction reads and writes back each live entry; if any entry was removed,
// all slots are cleared and each remaining entry is relinked (hash, then a read and a
// test per probed slot). After reset a clearing pass over all slots runs before the
// first word is taken. The block takes no word until the result is taken.
`default_nettype none
module aging_hash_table_store (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [31:0] key_id_i,
  input  wire logic [31:0] frame_stamp_i,
  input  wire logic [31:0] min_frame_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic [7:0]       entry_index_o,
  output logic [8:0]       removed_count_o
);
  import ahts_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_SLOT, S_KEY, S_CHECK, S_PRD, S_PRW,
    S_LHASH, S_LSLOT, S_LCHK, S_DONE
  } state_e;

  state_e state_q;
  logic [31:0] key_q, frame_q, minf_q;
  logic [1:0] mode_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W:0] probe_q;
  logic [CNT_W-1:0] live_q, rd_q, wr_q, link_q;
  logic [SV_W-1:0] sv_q;
  logic rebuild_q;

  logic [31:0] key_mem [ENTRIES];
  logic [31:0] stamp_mem [ENTRIES];
  logic [SV_W-1:0] slot_mem [SLOTS];
  logic [31:0] key_rd, stamp_rd;
  logic [SV_W-1:0] slot_rd;

  // memory ports
  logic km_we, sm_we, st_we;
  logic [IDX_W-1:0] e_addr, e_waddr;
  logic [31:0] km_wd, sm_wd;
  logic [SLOT_W-1:0] s_addr;
  logic [SV_W-1:0] st_wd;

  logic [31:0] mul_a;
  assign mul_a = (state_q == S_LCHK) ? key_rd : key_q;

  always_comb begin
    km_we = 1'b0; sm_we = 1'b0; st_we = 1'b0;
    e_addr = '0; e_waddr = '0; km_wd = key_q; sm_wd = frame_q;
    s_addr = slot_q; st_wd = '0;
    case (state_q)
      S_CLEAR: begin st_we = 1'b1; s_addr = slot_q; end
      S_KEY: e_addr = slot_rd[IDX_W-1:0] - 1'b1;
      S_PRD: e_addr = rd_q[IDX_W-1:0];
      S_PRW: begin
        e_waddr = wr_q[IDX_W-1:0];
        km_wd = key_rd; sm_wd = stamp_rd;
        km_we = (stamp_rd >= minf_q); sm_we = km_we;
      end
      S_LHASH: e_addr = link_q[IDX_W-1:0];
      S_LSLOT: begin
        st_wd = SV_W'(link_q) + 1'b1;
        st_we = probe_q[0] && (slot_rd == '0);
        e_addr = link_q[IDX_W-1:0];
      end
      S_CHECK: begin
        e_waddr = (slot_rd != '0) ? sv_q[IDX_W-1:0] - 1'b1 : live_q[IDX_W-1:0];
        if (mode_q == MODE_CREATE) begin
          if (slot_rd != '0 && key_rd == key_q) sm_we = 1'b1;
          else if (slot_rd == '0 && live_q < CNT_W'(ENTRIES)) begin
            sm_we = 1'b1; km_we = 1'b1; st_we = 1'b1;
            st_wd = SV_W'(live_q) + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (km_we) key_mem[e_waddr] <= km_wd;
    if (sm_we) stamp_mem[e_waddr] <= sm_wd;
    key_rd <= key_mem[e_addr];
    stamp_rd <= stamp_mem[e_addr];
    if (st_we) slot_mem[s_addr] <= st_wd;
    slot_rd <= slot_mem[s_addr];
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR; slot_q <= '0; live_q <= '0; out_valid_o <= 1'b0;
      status_o <= ST_ABSENT; entry_index_o <= '0; removed_count_o <= '0;
      probe_q <= '0; rd_q <= '0; wr_q <= '0; link_q <= '0; rebuild_q <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          slot_q <= slot_q + 1'b1;
          if (slot_q == SLOT_W'(SLOTS - 1)) begin
            if (rebuild_q) begin link_q <= '0; state_q <= S_LHASH; end
            else state_q <= S_IDLE;
          end
        end
        S_IDLE: if (in_valid_i) begin
          mode_q <= mode_i; key_q <= key_id_i; frame_q <= frame_stamp_i;
          minf_q <= min_frame_i; status_o <= ST_ABSENT; entry_index_o <= '0;
          removed_count_o <= '0; probe_q <= '0; rd_q <= '0; wr_q <= '0;
          if (mode_i == MODE_FIND || mode_i == MODE_CREATE) state_q <= S_HASH;
          else if (mode_i == MODE_PRUNE) begin
            status_o <= ST_PRUNED;
            state_q <= (live_q == '0) ? S_DONE : S_PRD;
          end else state_q <= S_DONE;
        end
        S_HASH: begin
          slot_q <= SLOT_W'(mul_a * HASH_MUL);
          state_q <= S_SLOT;
        end
        S_SLOT: state_q <= S_KEY;
        S_KEY: begin sv_q <= slot_rd; state_q <= S_CHECK; end
        S_CHECK: begin
          // slot_rd still holds this slot's word; key_rd its entry key
          if (slot_rd == '0) begin
            if (mode_q == MODE_CREATE) begin
              if (live_q < CNT_W'(ENTRIES)) begin
                status_o <= ST_CREATED; entry_index_o <= 8'(live_q);
                live_q <= live_q + 1'b1;
              end else status_o <= ST_FULL;
            end
            state_q <= S_DONE;
          end else if (key_rd == key_q) begin
            status_o <= ST_FOUND; entry_index_o <= 8'(sv_q - 1'b1);
            state_q <= S_DONE;
          end else if (probe_q == (SLOT_W+1)'(SLOTS - 1)) begin
            if (mode_q == MODE_CREATE && live_q >= CNT_W'(ENTRIES))
              status_o <= ST_FULL;
            state_q <= S_DONE;
          end else begin
            probe_q <= probe_q + 1'b1; slot_q <= slot_q + 1'b1; state_q <= S_SLOT;
          end
        end
        S_PRD: state_q <= S_PRW;
        S_PRW: begin
          if (stamp_rd >= minf_q) wr_q <= wr_q + 1'b1;
          rd_q <= rd_q + 1'b1;
          if (rd_q + 1'b1 == live_q) begin
            if (stamp_rd >= minf_q) begin
              removed_count_o <= 9'(live_q - wr_q - 1'b1);
              live_q <= wr_q + 1'b1;
              rebuild_q <= (live_q != wr_q + 1'b1);
              state_q <= (live_q != wr_q + 1'b1) ? S_CLEAR : S_DONE;
            end else begin
              removed_count_o <= 9'(live_q - wr_q);
              live_q <= wr_q; rebuild_q <= 1'b1; state_q <= S_CLEAR;
            end
            slot_q <= '0;
          end else state_q <= S_PRD;
        end
        S_LHASH: begin
          if (link_q == live_q) begin rebuild_q <= 1'b0; state_q <= S_DONE; end
          else state_q <= S_LCHK;
        end
        S_LCHK: begin
          slot_q <= SLOT_W'(mul_a * HASH_MUL);
          state_q <= S_LSLOT; probe_q <= '0;
        end
        S_LSLOT: begin
          // with probe_q[0] low the slot is read; with it high, test, then link or advance
          if (probe_q[0] == 1'b0) probe_q <= (SLOT_W+1)'(1);
          else if (slot_rd == '0) begin
            link_q <= link_q + 1'b1; state_q <= S_LHASH;
          end else begin slot_q <= slot_q + 1'b1; probe_q <= '0; end
        end
        S_DONE: begin
          out_valid_o <= 1'b1;
          if (out_valid_o && out_ready_i) begin
            out_valid_o <= 1'b0; state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("ready while result pending");
  a_live_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    live_q <= CNT_W'(ENTRIES)) else $error("live count overflow");
  a_prune_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_PRUNED) |-> entry_index_o == '0)
    else $error("prune gave index");
endmodule
`default_nettype wire

>>> test/tb_aging_hash_table_store.sv
// Testbench for aging_hash_table_store: queue-fed driver, checking monitor, watchdog.
// Keeps its own model of the entry array and slot table to predict each result word.
// Depends on ahts_pkg and the RTL top level.
`timescale 1ns / 100ps
module tb_aging_hash_table_store;
  import ahts_pkg::*;

  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam int WATCH_LIMIT = 400000;
  localparam int FREE_LO = 3000;
  localparam int FREE_HI = 6000;
  localparam int HOLD_AT = 700;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] key;
    logic [31:0] frame;
    logic [31:0] minf;
    logic        drain;
  } op_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] index;
    logic [8:0] removed;
  } res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = '0;
  logic [31:0] key_id_i = '0;
  logic [31:0] frame_stamp_i = '0;
  logic [31:0] min_frame_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  entry_index_o;
  logic [8:0]  removed_count_o;

  aging_hash_table_store u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .mode_i(mode_i), .key_id_i(key_id_i),
    .frame_stamp_i(frame_stamp_i), .min_frame_i(min_frame_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i),
    .status_o(status_o), .entry_index_o(entry_index_o),
    .removed_count_o(removed_count_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  op_t  pending_ops[$];
  res_t expected_res[$];
  logic [31:0] key_pool[$];
  int   mismatches = 0;
  int   cycle_no = 0;
  int   results_seen = 0;
  int   hold_left = 0;
  bit   hold_done = 0;

  // model state
  logic [31:0] m_key[ENTRIES];
  logic [31:0] m_stamp[ENTRIES];
  logic [SV_W-1:0] m_slot[SLOTS];
  int unsigned m_live = 0;

  function automatic int unsigned home_of(logic [31:0] key);
    logic [31:0] p;
    p = key * HASH_MUL;
    return p[SLOT_W-1:0];
  endfunction

  function automatic int find_entry(logic [31:0] key);
    int unsigned s;
    s = home_of(key);
    for (int n = 0; n < SLOTS; n++) begin
      if (m_slot[s] == 0) return -1;
      if (m_key[m_slot[s] - 1] == key) return int'(m_slot[s]) - 1;
      s = (s + 1) % SLOTS;
    end
    return -1;
  endfunction

  task automatic link_entry(int unsigned idx);
    int unsigned s;
    s = home_of(m_key[idx]);
    for (int n = 0; n < SLOTS; n++) begin
      if (m_slot[s] == 0) begin
        m_slot[s] = SV_W'(idx + 1);
        return;
      end
      s = (s + 1) % SLOTS;
    end
  endtask

  task automatic predict_store(op_t op);
    res_t r;
    int f;
    int unsigned w;
    r = '{status: ST_ABSENT, index: '0, removed: '0};
    if (op.mode == MODE_FIND || op.mode == MODE_CREATE) begin
      f = find_entry(op.key);
      if (f >= 0) begin
        r.status = ST_FOUND;
        r.index = f[7:0];
        if (op.mode == MODE_CREATE) m_stamp[f] = op.frame;
      end else if (op.mode == MODE_CREATE) begin
        if (m_live >= ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          m_key[m_live] = op.key;
          m_stamp[m_live] = op.frame;
          link_entry(m_live);
          r.status = ST_CREATED;
          r.index = m_live[7:0];
          m_live++;
        end
      end
    end else if (op.mode == MODE_PRUNE) begin
      w = 0;
      for (int unsigned i = 0; i < m_live; i++) begin
        if (m_stamp[i] >= op.minf) begin
          m_key[w] = m_key[i];
          m_stamp[w] = m_stamp[i];
          w++;
        end
      end
      r.status = ST_PRUNED;
      r.removed = 9'(m_live - w);
      m_live = w;
      if (r.removed != 0) begin
        foreach (m_slot[s]) m_slot[s] = '0;
        for (int unsigned i = 0; i < m_live; i++) link_entry(i);
      end
    end
    expected_res.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)",
             what, got, want, results_seen);
    mismatches++;
  endtask

  function automatic bit idle_now();
    if (cycle_no > FREE_LO && cycle_no < FREE_HI) return 0;
    return $urandom_range(99) < 22;
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic next_valid;
    op_t op;
    next_valid = in_valid_i;
    if (rst_ni) begin
      cycle_no <= cycle_no + 1;
      if (in_valid_i && in_ready_o) begin
        predict_store('{mode: mode_i, key: key_id_i, frame: frame_stamp_i,
                        minf: min_frame_i, drain: 1'b0});
        next_valid = 1'b0;
      end
      if (!next_valid && pending_ops.size() > 0 && !idle_now()) begin
        // hold the drain marker until every outstanding word has returned
        if (!pending_ops[0].drain || expected_res.size() == 0) begin
          op = pending_ops.pop_front();
          mode_i <= op.mode;
          key_id_i <= op.key;
          frame_stamp_i <= op.frame;
          min_frame_i <= op.minf;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_res.size() == 0) begin
          report_mismatch("unexpected result word", 1, 0);
        end else begin
          want = expected_res.pop_front();
          if (status_o != want.status) report_mismatch("status", status_o, want.status);
          if (entry_index_o != want.index)
            report_mismatch("entry_index", entry_index_o, want.index);
          if (removed_count_o != want.removed)
            report_mismatch("removed_count", removed_count_o, want.removed);
        end
        results_seen <= results_seen + 1;
      end
      if (!hold_done && results_seen == HOLD_AT) begin
        hold_done <= 1;
        hold_left <= HOLD_LEN;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !idle_now();
      end
    end
  end

  // watchdog
  int quiet = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= WATCH_LIMIT) begin
        $display("aging_hash_table_store test failed");
        $finish;
      end
    end
  end

  task automatic add_op(logic [1:0] mode, logic [31:0] key, logic [31:0] frame,
                        logic [31:0] minf, bit drain = 0);
    pending_ops.push_back('{mode: mode, key: key, frame: frame, minf: minf, drain: drain});
    if (mode == MODE_CREATE) begin
      key_pool.push_back(key);
      if (key_pool.size() > 400) void'(key_pool.pop_front());
    end
  endtask

  function automatic logic [31:0] pick_key();
    if (key_pool.size() == 0 || $urandom_range(99) < 25) return $urandom();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  initial begin
    logic [31:0] frame;
    int unsigned roll;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty store, extremes, refresh, prune bounds, unused mode
    add_op(MODE_FIND, 32'h0, 32'h0, 32'h0);
    add_op(MODE_PRUNE, 32'h0, 32'h0, 32'hFFFF_FFFF);
    add_op(MODE_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(MODE_CREATE, 32'h0, 32'h0, 32'h0);
    add_op(MODE_CREATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    add_op(MODE_CREATE, 32'h0000_0200, 32'd10, 32'h0);
    add_op(MODE_FIND, 32'h0, 32'h5, 32'h0);
    add_op(MODE_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_op(MODE_FIND, 32'h1234_5678, 32'h0, 32'h0);
    add_op(MODE_CREATE, 32'h0, 32'd20, 32'h0);
    add_op(MODE_PRUNE, 32'h0, 32'h0, 32'h0);
    add_op(MODE_PRUNE, 32'h0, 32'h0, 32'd15);
    add_op(MODE_FIND, 32'h0000_0200, 32'h0, 32'h0);
    add_op(MODE_FIND, 32'h0, 32'h0, 32'h0);
    add_op(MODE_PRUNE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(MODE_FIND, 32'hFFFF_FFFF, 32'h0, 32'h0);
    add_op(MODE_PRUNE, 32'h0, 32'h0, 32'hFFFF_FFFF, 1);

    // fill past capacity to reach the full status
    frame = 32'd100;
    for (int i = 0; i < 290; i++) begin
      frame += $urandom_range(1);
      add_op(MODE_CREATE, $urandom(), frame, $urandom());
    end
    add_op(MODE_FIND, pick_key(), frame, 32'h0);
    add_op(MODE_PRUNE, $urandom(), frame, frame - 32'd60);

    for (int i = 0; i < 1500; i++) begin
      roll = $urandom_range(99);
      frame += $urandom_range(3);
      if (roll < 35)
        add_op(MODE_FIND, pick_key(), $urandom(), $urandom(), i == 800);
      else if (roll < 88)
        add_op(MODE_CREATE, pick_key(),
               ($urandom_range(19) == 0) ? $urandom() : frame, $urandom());
      else if (roll < 96)
        add_op(MODE_PRUNE, $urandom(), $urandom(),
               ($urandom_range(9) == 0) ? $urandom() : frame - $urandom_range(300));
      else
        add_op(MODE_NOP, $urandom(), $urandom(), $urandom());
    end

    wait (pending_ops.size() == 0 && !in_valid_i && expected_res.size() == 0);
    repeat (3000) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("aging_hash_table_store test passed");
    end else begin
      $display("aging_hash_table_store test failed");
    end
    $finish;
  end
endmodule
